FILE: rtl/core/rmj_pkg.sv
// radar jacobian shared package: guard register type and reset value
// no dependencies; used by the channel interfaces and the top level
package rmj_pkg;

  localparam int GUARD_BITS = 16;

  typedef logic [GUARD_BITS-1:0] guard_t;

  localparam guard_t GUARD_RESET = 16'd7;

endpackage

FILE: rtl/core/rmj_if.sv
// channel interfaces: state vector in, jacobian entries out, guard register write
// depends on rmj_pkg for the guard register type
interface rmj_in_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] pos_x;
  logic signed [WORD_BITS-1:0] pos_y;
  logic signed [WORD_BITS-1:0] vel_x;
  logic signed [WORD_BITS-1:0] vel_y;

  modport source(output valid, pos_x, pos_y, vel_x, vel_y, input ready);
  modport sink(input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface rmj_out_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] range_dx;
  logic signed [WORD_BITS-1:0] range_dy;
  logic signed [WORD_BITS-1:0] bearing_dx;
  logic signed [WORD_BITS-1:0] bearing_dy;
  logic signed [WORD_BITS-1:0] rate_dx;
  logic signed [WORD_BITS-1:0] rate_dy;
  logic                        guard_used;
  logic                        saturated;

  modport source(output valid, range_dx, range_dy, bearing_dx, bearing_dy, rate_dx, rate_dy,
                 guard_used, saturated, input ready);
  modport sink(input valid, range_dx, range_dy, bearing_dx, bearing_dy, rate_dx, rate_dy,
               guard_used, saturated, output ready);
endinterface

interface rmj_cfg_if import rmj_pkg::*; ();
  logic   valid;
  logic   ready;
  guard_t data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

FILE: rtl/core/rmj_mul_chain.sv
// shift-add multiplier as a row of cells, one multiplier bit per cell, several lanes
// no package dependencies; a side vector rides along with each beat
module rmj_mul_chain #(
  parameter int LANES = 1,
  parameter int AW    = 8,
  parameter int BW    = 8,
  parameter int SW    = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [SW-1:0]                  in_side,
  input  logic [LANES-1:0][AW-1:0]       in_a,
  input  logic [LANES-1:0][BW-1:0]       in_b,
  output logic                           out_valid,
  output logic [SW-1:0]                  out_side,
  output logic [LANES-1:0][AW+BW-1:0]    out_p
);

  localparam int PW = AW + BW;

  logic                           vld  [BW+1];
  logic [SW-1:0]                  side [BW+1];
  logic [LANES-1:0][AW-1:0]       av   [BW+1];
  logic [LANES-1:0][BW-1:0]       bv   [BW+1];
  logic [LANES-1:0][PW-1:0]       acc  [BW+1];

  assign vld[0]  = in_valid;
  assign side[0] = in_side;
  assign av[0]   = in_a;
  assign bv[0]   = in_b;
  assign acc[0]  = '0;

  for (genvar k = 0; k < BW; k++) begin : g_cell
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[k+1] <= side[k];
        av[k+1]   <= av[k];
        bv[k+1]   <= bv[k];
        for (int l = 0; l < LANES; l++) begin
          // partial product row for multiplier bit k
          acc[k+1][l] <= acc[k][l] + (bv[k][l][k] ? (PW'(av[k][l]) << k) : PW'(0));
        end
      end
    end
  end

  assign out_valid = vld[BW];
  assign out_side  = side[BW];
  assign out_p     = acc[BW];

endmodule

FILE: rtl/core/rmj_root_chain.sv
// digit recurrence row of cells: per lane floor(n/d) or floor(sqrt(n/d)), one result bit a cell
// results clip to all ones when they do not fit; no package dependencies
module rmj_root_chain #(
  parameter int               LANES     = 1,
  parameter int               NW        = 16,
  parameter int               DW        = 8,
  parameter int               NB        = 8,
  parameter int               SW        = 1,
  parameter logic [LANES-1:0] LANE_SQRT = '0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [SW-1:0]             in_side,
  input  logic [LANES-1:0][NW-1:0]  in_n,
  input  logic [LANES-1:0][DW-1:0]  in_d,
  output logic                      out_valid,
  output logic [SW-1:0]             out_side,
  output logic [LANES-1:0][NB-1:0]  out_q
);

  localparam int TW = DW + NB;
  localparam int CW = (NW > DW + 2 * NB + 1) ? NW : DW + 2 * NB + 1;

  logic                      vld  [NB+1];
  logic [SW-1:0]             side [NB+1];
  logic [LANES-1:0][CW-1:0]  rem  [NB+1];
  logic [LANES-1:0][TW-1:0]  tacc [NB+1];
  logic [LANES-1:0][DW-1:0]  dv   [NB+1];
  logic [LANES-1:0][NB-1:0]  q    [NB+1];

  assign vld[0]  = in_valid;
  assign side[0] = in_side;
  assign dv[0]   = in_d;
  assign tacc[0] = '0;
  assign q[0]    = '0;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem[0][l] = CW'(in_n[l]);
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_cell
    localparam int B = NB - 1 - k;

    logic [LANES-1:0][CW-1:0] cost;
    logic [LANES-1:0]         fit;

    // rem holds n - s*s*d (or n - s*d), tacc holds s*d
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if (LANE_SQRT[l]) begin
          cost[l] = (CW'(tacc[k][l]) << (B + 1)) + (CW'(dv[k][l]) << (2 * B));
        end else begin
          cost[l] = CW'(dv[k][l]) << B;
        end
        fit[l] = (cost[l] <= rem[k][l]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[k+1] <= side[k];
        dv[k+1]   <= dv[k];
        for (int l = 0; l < LANES; l++) begin
          if (fit[l]) begin
            rem[k+1][l]  <= rem[k][l] - cost[l];
            tacc[k+1][l] <= tacc[k][l] + (TW'(dv[k][l]) << B);
          end else begin
            rem[k+1][l]  <= rem[k][l];
            tacc[k+1][l] <= tacc[k][l];
          end
          q[k+1][l] <= q[k][l] | (NB'(fit[l]) << B);
        end
      end
    end
  end

  assign out_valid = vld[NB];
  assign out_side  = side[NB];
  assign out_q     = q[NB];

endmodule

FILE: rtl/core/radar_measurement_jacobian.sv
// radar range/bearing/range-rate jacobian, fully pipelined rows of shift-add cells
// stages in order: input register, a WORD_BITS-cell multiplier row, a combine register,
// two multiplier rows of 2*WORD_BITS cells, two parallel WORD_BITS-cell divide/root rows
// and the output register; one state vector accepted every cycle unless the output stalls
// reset clears all beat valid bits and loads the zero guard register with 7
// depends on rmj_pkg, rmj_if, rmj_mul_chain and rmj_root_chain
module radar_measurement_jacobian
  import rmj_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  rmj_cfg_if.sink  cfg,
  rmj_in_if.sink   state,
  rmj_out_if.source jacobian
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int S1W = 2 * W + 5;
  localparam int S2W = 8 * W + 4;
  localparam int NA  = 2 * W + 3 * F;
  localparam int NBW = 6 * W + 2 * F;
  localparam logic signed [W-1:0] ONE_Q = W'(64'd1 << F);

  function automatic logic [W:0] finish(input logic neg, input logic [W-1:0] mag);
    logic [W-1:0] lim;
    logic [W-1:0] r;
    logic         s;
    lim = {1'b1, {(W-1){1'b0}}};
    if (mag[W-1]) begin
      if (neg && (mag == lim)) begin
        s = 1'b0;
        r = lim;
      end else begin
        s = 1'b1;
        r = neg ? lim : ~lim;
      end
    end else begin
      s = 1'b0;
      r = neg ? (~mag + 1'b1) : mag;
    end
    return {s, r};
  endfunction

  // guard register
  guard_t zero_guard_x;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_guard_x <= GUARD_RESET;
    end else if (cfg.valid) begin
      zero_guard_x <= cfg.data;
    end
  end

  // pipeline advance: stall only when a finished beat meets a full output register that is not ready
  logic take;
  logic en;
  logic a_vld;
  logic b_vld;

  assign take        = !jacobian.valid || jacobian.ready;
  assign en          = take || !a_vld;
  assign state.ready = en;

  // sign and magnitude split
  logic [W-1:0] px_raw, py_raw, vx_raw, vy_raw;
  logic [W-1:0] ax, ay, avx, avy;
  logic         zero_pos;
  guard_t       gsel;

  assign px_raw   = state.pos_x;
  assign py_raw   = state.pos_y;
  assign vx_raw   = state.vel_x;
  assign vy_raw   = state.vel_y;
  assign ax       = px_raw[W-1] ? (~px_raw + 1'b1) : px_raw;
  assign ay       = py_raw[W-1] ? (~py_raw + 1'b1) : py_raw;
  assign avx      = vx_raw[W-1] ? (~vx_raw + 1'b1) : vx_raw;
  assign avy      = vy_raw[W-1] ? (~vy_raw + 1'b1) : vy_raw;
  assign zero_pos = (ax == '0) && (ay == '0);
  // a zero guard acts as one lsb
  assign gsel     = (zero_guard_x == '0) ? GUARD_BITS'(1) : zero_guard_x;

  logic         r0_vld;
  logic         r0_nx, r0_ny, r0_nvx, r0_nvy, r0_guard;
  logic [W-1:0] r0_mx, r0_my, r0_mvx, r0_mvy;

  always_ff @(posedge clk) begin
    if (rst) begin
      r0_vld <= 1'b0;
    end else if (en) begin
      r0_vld <= state.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0_nx    <= zero_pos ? 1'b0 : px_raw[W-1];
      r0_ny    <= py_raw[W-1];
      r0_nvx   <= vx_raw[W-1];
      r0_nvy   <= vy_raw[W-1];
      r0_guard <= zero_pos;
      r0_mx    <= zero_pos ? W'(gsel) : ax;
      r0_my    <= ay;
      r0_mvx   <= avx;
      r0_mvy   <= avy;
    end
  end

  // squares and cross products
  logic                   g1_vld;
  logic [S1W-1:0]         g1_side;
  logic [3:0][2*W-1:0]    g1_p;

  rmj_mul_chain #(.LANES(4), .AW(W), .BW(W), .SW(S1W)) u_mul_sq (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (r0_vld),
    .in_side  ({r0_nx, r0_ny, r0_nvx, r0_nvy, r0_guard, r0_mx, r0_my}),
    .in_a     ({r0_mvy, r0_mvx, r0_my, r0_mx}),
    .in_b     ({r0_mx, r0_my, r0_my, r0_mx}),
    .out_valid(g1_vld),
    .out_side (g1_side),
    .out_p    (g1_p)
  );

  logic         u1_nx, u1_ny, u1_nvx, u1_nvy, u1_guard;
  logic [W-1:0] u1_mx, u1_my;

  assign {u1_nx, u1_ny, u1_nvx, u1_nvy, u1_guard, u1_mx, u1_my} = g1_side;

  // cross term vx*py - vy*px as sign and magnitude
  logic           s1, s2, cn_c;
  logic [2*W-1:0] cm_c;

  always_comb begin
    s1 = u1_nvx ^ u1_ny;
    s2 = ~(u1_nvy ^ u1_nx);
    if (s1 == s2) begin
      cm_c = g1_p[2] + g1_p[3];
      cn_c = s1;
    end else if (g1_p[2] >= g1_p[3]) begin
      cm_c = g1_p[2] - g1_p[3];
      cn_c = s1;
    end else begin
      cm_c = g1_p[3] - g1_p[2];
      cn_c = s2;
    end
  end

  logic           r1_vld;
  logic           r1_nx, r1_ny, r1_cn, r1_guard;
  logic [W-1:0]   r1_mx, r1_my;
  logic [2*W-1:0] r1_x2, r1_y2, r1_r2, r1_cm;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_vld <= 1'b0;
    end else if (en) begin
      r1_vld <= g1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_nx    <= u1_nx;
      r1_ny    <= u1_ny;
      r1_cn    <= cn_c;
      r1_guard <= u1_guard;
      r1_mx    <= u1_mx;
      r1_my    <= u1_my;
      r1_x2    <= g1_p[0];
      r1_y2    <= g1_p[1];
      r1_r2    <= g1_p[0] + g1_p[1];
      r1_cm    <= cm_c;
    end
  end

  // c squared and r2 squared
  logic                g2_vld;
  logic [S2W-1:0]      g2_side;
  logic [1:0][4*W-1:0] g2_p;

  rmj_mul_chain #(.LANES(2), .AW(2 * W), .BW(2 * W), .SW(S2W)) u_mul_quad (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (r1_vld),
    .in_side  ({r1_nx, r1_ny, r1_cn, r1_guard, r1_mx, r1_my, r1_x2, r1_y2, r1_r2}),
    .in_a     ({r1_r2, r1_cm}),
    .in_b     ({r1_r2, r1_cm}),
    .out_valid(g2_vld),
    .out_side (g2_side),
    .out_p    (g2_p)
  );

  logic [2*W-1:0] u2_x2, u2_y2, u2_r2;

  assign {u2_x2, u2_y2, u2_r2} = g2_side[6*W-1:0];

  // y2*c2, x2*c2 and r2 cubed
  logic                g3_vld;
  logic [S2W-1:0]      g3_side;
  logic [2:0][6*W-1:0] g3_p;

  rmj_mul_chain #(.LANES(3), .AW(4 * W), .BW(2 * W), .SW(S2W)) u_mul_six (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (g2_vld),
    .in_side  (g2_side),
    .in_a     ({g2_p[1], g2_p[0], g2_p[0]}),
    .in_b     ({u2_r2, u2_x2, u2_y2}),
    .out_valid(g3_vld),
    .out_side (g3_side),
    .out_p    (g3_p)
  );

  logic           u3_nx, u3_ny, u3_cn, u3_guard;
  logic [W-1:0]   u3_mx, u3_my;
  logic [2*W-1:0] u3_x2, u3_y2, u3_r2;

  assign {u3_nx, u3_ny, u3_cn, u3_guard, u3_mx, u3_my, u3_x2, u3_y2, u3_r2} = g3_side;

  // range roots and bearing quotients over r2
  logic [2:0]          ua_side;
  logic [3:0][W-1:0]   qa;

  rmj_root_chain #(
    .LANES(4), .NW(NA), .DW(2 * W), .NB(W), .SW(3), .LANE_SQRT(4'b0011)
  ) u_root_pos (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (g3_vld),
    .in_side  ({u3_nx, u3_ny, u3_guard}),
    .in_n     ({NA'(u3_mx) << (3 * F), NA'(u3_my) << (3 * F),
                NA'(u3_y2) << (2 * F), NA'(u3_x2) << (2 * F)}),
    .in_d     ({4{u3_r2}}),
    .out_valid(a_vld),
    .out_side (ua_side),
    .out_q    (qa)
  );

  // range-rate roots over r2 cubed
  logic              ub_cn;
  logic [1:0][W-1:0] qb;

  rmj_root_chain #(
    .LANES(2), .NW(NBW), .DW(6 * W), .NB(W), .SW(1), .LANE_SQRT(2'b11)
  ) u_root_rate (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (g3_vld),
    .in_side  (u3_cn),
    .in_n     ({NBW'(g3_p[1]) << (2 * F), NBW'(g3_p[0]) << (2 * F)}),
    .in_d     ({2{g3_p[2]}}),
    .out_valid(b_vld),
    .out_side (ub_cn),
    .out_q    (qb)
  );

  logic     ua_nx, ua_ny, ua_guard;
  logic [W:0] f0, f1, f2, f3, f4, f5;

  assign {ua_nx, ua_ny, ua_guard} = ua_side;

  assign f0 = finish(ua_nx, qa[0]);
  assign f1 = finish(ua_ny, qa[1]);
  assign f2 = finish(~ua_ny, qa[2]);
  assign f3 = finish(ua_nx, qa[3]);
  assign f4 = finish(ua_ny ^ ub_cn, qb[0]);
  assign f5 = finish(~(ua_nx ^ ub_cn), qb[1]);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      jacobian.valid <= 1'b0;
    end else if (take) begin
      jacobian.valid <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (take && a_vld) begin
      jacobian.range_dx   <= f0[W-1:0];
      jacobian.range_dy   <= f1[W-1:0];
      jacobian.bearing_dx <= f2[W-1:0];
      jacobian.bearing_dy <= f3[W-1:0];
      jacobian.rate_dx    <= f4[W-1:0];
      jacobian.rate_dy    <= f5[W-1:0];
      jacobian.guard_used <= ua_guard;
      jacobian.saturated  <= f0[W] | f1[W] | f2[W] | f3[W] | f4[W] | f5[W];
    end
  end

  // both root rows see the same beats
  a_rows_aligned: assert property (@(posedge clk) disable iff (rst) a_vld == b_vld)
    else $error("root rows out of step");

  // a guarded beat has zero y position, so the y-driven entries vanish
  a_guard_zero_y: assert property (@(posedge clk) disable iff (rst)
    (jacobian.valid && jacobian.guard_used) |->
      (jacobian.range_dy == '0 && jacobian.bearing_dx == '0 && jacobian.rate_dx == '0))
    else $error("guarded beat with nonzero y entries");

  // px over range never exceeds one in magnitude
  a_range_bound: assert property (@(posedge clk) disable iff (rst)
    jacobian.valid |-> (jacobian.range_dx <= ONE_Q && jacobian.range_dx >= -ONE_Q))
    else $error("range entry out of unit bound");

endmodule
